### sv/fqkd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqkd_pkg: shared definitions for the keyed first-in first-out queue
// Queue depth, field widths, command and status codes, and the command
// bundle that the top level broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package fqkd_pkg;

   // Number of entries held by the queue (2 to 31, so that the count fits in OCC_W bits).
   localparam int DEPTH = 16;

   // Field widths.
   localparam int KIND_W = 2;
   localparam int KEY_W  = 40;
   localparam int PAY_W  = 32;
   localparam int STAT_W = 2;
   localparam int OCC_W  = 5;

   // Cell index and entry count widths follow from the depth.
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Command codes.
   localparam logic [KIND_W-1:0] KIND_ENQUEUE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DEQUEUE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DELETE  = 2'd2;

   // Status codes.
   localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

   // Command broadcast to every cell in the chain for one accepted beat.
   typedef struct packed {
      logic             do_enqueue;  // enqueue with a free slot
      logic             do_dequeue;  // dequeue with at least one entry
      logic             do_delete;   // delete by key
      logic [CNT_W-1:0] count;       // entries held before the command
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } cmd_type;

endpackage

### sv/fqkd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqkd_cell: one storage slot of the keyed queue
// Holds one key and payload. Compares its key with the broadcast key, passes
// a match flag down the chain, and shifts in its neighbour's entry when an
// entry nearer the head is removed.
// ----------------------------------------------------------------------------
module fqkd_cell (
   input  logic                         clock,
   input  logic [fqkd_pkg::IDX_W-1:0]   cell_index,
   input  fqkd_pkg::cmd_type            cmd,
   input  logic                         found_in,
   input  logic [fqkd_pkg::KEY_W-1:0]   next_key,
   input  logic [fqkd_pkg::PAY_W-1:0]   next_payload,
   output logic                         found_out,
   output logic [fqkd_pkg::KEY_W-1:0]   key,
   output logic [fqkd_pkg::PAY_W-1:0]   payload
);

   logic [fqkd_pkg::KEY_W-1:0] key_ff;
   logic [fqkd_pkg::KEY_W-1:0] key_in;
   logic [fqkd_pkg::PAY_W-1:0] payload_ff;
   logic [fqkd_pkg::PAY_W-1:0] payload_in;
   logic [fqkd_pkg::CNT_W-1:0] index_wide;
   logic                       occupied;
   logic                       match;
   logic                       shift;
   logic                       load;

   // The slot is live when its position lies below the entry count.
   assign index_wide = fqkd_pkg::CNT_W'(cell_index);
   assign occupied   = (index_wide < cmd.count);

   // Match flag ripples from the head, so only the first match counts.
   assign match     = cmd.do_delete && occupied && (key_ff == cmd.key);
   assign found_out = found_in || match;

   // Removal at or above this slot pulls the neighbour's entry up.
   assign shift = cmd.do_dequeue || (cmd.do_delete && found_out);
   assign load  = cmd.do_enqueue && (index_wide == cmd.count);

   always_comb begin
      key_in     = key_ff;
      payload_in = payload_ff;
      if (shift) begin
         key_in     = next_key;
         payload_in = next_payload;
      end else if (load) begin
         key_in     = cmd.key;
         payload_in = cmd.payload;
      end
   end

   // Entry storage needs no reset: slots above the count are never read.
   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

   assign key     = key_ff;
   assign payload = payload_ff;

endmodule

### sv/fifo_queue_with_key_delete.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_key_delete: ordered queue with delete by key
// Top level: a chain of storage cells, the entry count and the result register.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one command per beat: enqueue (key and payload
//   appended at the tail), dequeue (head entry returned) or delete (first
//   entry from the head with a matching key removed, the gap closed up).
//   The rsp_ channel returns exactly one result beat per command, with a
//   status code, the dequeued key and payload (zero otherwise) and the
//   number of entries held afterwards.
//   A result beat follows its request beat in the next cycle; a command is
//   taken every cycle while req_stall is low. Keys are compared in all cells
//   at once; the match flag ripples along the chain, setting the cycle time.
//   A result waiting in the output register does not block a new command
//   while the receiver takes it in that same cycle; req_stall rises only when
//   the result register is full and rsp_stall is high.
//   Reset empties the queue at once and drops any pending result; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module fifo_queue_with_key_delete (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [fqkd_pkg::KIND_W-1:0]   req_kind,
   input  logic [fqkd_pkg::KEY_W-1:0]    req_in_key,
   input  logic [fqkd_pkg::PAY_W-1:0]    req_in_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fqkd_pkg::STAT_W-1:0]   rsp_status,
   output logic [fqkd_pkg::KEY_W-1:0]    rsp_out_key,
   output logic [fqkd_pkg::PAY_W-1:0]    rsp_out_payload,
   output logic [fqkd_pkg::OCC_W-1:0]    rsp_occupancy
);

   localparam logic [fqkd_pkg::CNT_W-1:0] FULL_COUNT =
      fqkd_pkg::CNT_W'(fqkd_pkg::DEPTH);

   fqkd_pkg::cmd_type          cmd;
   logic                       req_accept;
   logic                       is_enqueue;
   logic                       is_dequeue;
   logic                       is_delete;
   logic                       is_full;
   logic                       is_empty;
   logic                       deleted;
   logic [fqkd_pkg::CNT_W-1:0] count_ff;
   logic [fqkd_pkg::CNT_W-1:0] count_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [fqkd_pkg::STAT_W-1:0] status_ff;
   logic [fqkd_pkg::STAT_W-1:0] status_in;
   logic [fqkd_pkg::KEY_W-1:0] out_key_ff;
   logic [fqkd_pkg::KEY_W-1:0] out_key_in;
   logic [fqkd_pkg::PAY_W-1:0] out_payload_ff;
   logic [fqkd_pkg::PAY_W-1:0] out_payload_in;
   logic [fqkd_pkg::OCC_W-1:0] occupancy_ff;
   logic [fqkd_pkg::OCC_W-1:0] occupancy_in;

   logic [fqkd_pkg::KEY_W-1:0] cell_key [fqkd_pkg::DEPTH];
   logic [fqkd_pkg::PAY_W-1:0] cell_payload [fqkd_pkg::DEPTH];
   logic                       found_chain [fqkd_pkg::DEPTH+1];

   // Handshake: a new beat is taken unless a result is held and stalled.
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // Command decode.
   assign is_enqueue = (req_kind == fqkd_pkg::KIND_ENQUEUE);
   assign is_dequeue = (req_kind == fqkd_pkg::KIND_DEQUEUE);
   assign is_delete  = (req_kind == fqkd_pkg::KIND_DELETE);
   assign is_full    = (count_ff >= FULL_COUNT);
   assign is_empty   = (count_ff == '0);

   assign cmd.do_enqueue = req_accept && is_enqueue && !is_full;
   assign cmd.do_dequeue = req_accept && is_dequeue && !is_empty;
   assign cmd.do_delete  = req_accept && is_delete;
   assign cmd.count      = count_ff;
   assign cmd.key        = req_in_key;
   assign cmd.payload    = req_in_payload;

   // Cell chain: each cell takes its neighbour's entry on a shift.
   assign found_chain[0] = 1'b0;

   for (genvar i = 0; i < fqkd_pkg::DEPTH; i++) begin : g_cell
      logic [fqkd_pkg::KEY_W-1:0] nb_key;
      logic [fqkd_pkg::PAY_W-1:0] nb_payload;

      if (i == fqkd_pkg::DEPTH - 1) begin : g_last
         assign nb_key     = cell_key[i];
         assign nb_payload = cell_payload[i];
      end else begin : g_mid
         assign nb_key     = cell_key[i+1];
         assign nb_payload = cell_payload[i+1];
      end

      fqkd_cell u_cell (
         .clock        (clock),
         .cell_index   (fqkd_pkg::IDX_W'(i)),
         .cmd          (cmd),
         .found_in     (found_chain[i]),
         .next_key     (nb_key),
         .next_payload (nb_payload),
         .found_out    (found_chain[i+1]),
         .key          (cell_key[i]),
         .payload      (cell_payload[i])
      );
   end

   assign deleted = found_chain[fqkd_pkg::DEPTH];

   // Entry count and result for the accepted beat.
   always_comb begin
      count_in       = count_ff;
      status_in      = fqkd_pkg::STAT_DONE;
      out_key_in     = '0;
      out_payload_in = '0;
      if (cmd.do_enqueue) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.do_dequeue) begin
         count_in       = count_ff - 1'b1;
         out_key_in     = cell_key[0];
         out_payload_in = cell_payload[0];
      end else if (cmd.do_delete && deleted) begin
         count_in = count_ff - 1'b1;
      end
      if (is_enqueue && is_full) begin
         status_in = fqkd_pkg::STAT_FULL;
      end else if (is_dequeue && is_empty) begin
         status_in = fqkd_pkg::STAT_EMPTY;
      end else if (is_delete && !deleted) begin
         status_in = fqkd_pkg::STAT_NOT_FOUND;
      end
      occupancy_in = fqkd_pkg::OCC_W'(count_in);
   end

   // The result register fills on an accepted beat and empties when taken.
   assign rsp_valid_in = req_accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         status_ff      <= status_in;
         out_key_ff     <= out_key_in;
         out_payload_ff <= out_payload_in;
         occupancy_ff   <= occupancy_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_out_key     = out_key_ff;
   assign rsp_out_payload = out_payload_ff;
   assign rsp_occupancy   = occupancy_ff;

endmodule

### tb/sv/fqkd_queue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqkd_queue_checker: result checker for the keyed first-in first-out queue
// Watches the req_ and rsp_ channels and keeps its own copy of the queue. Each
// accepted command beat gives one expected result beat. Each accepted result
// beat is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module fqkd_queue_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [fqkd_pkg::KIND_W-1:0]   req_kind,
   input  logic [fqkd_pkg::KEY_W-1:0]    req_in_key,
   input  logic [fqkd_pkg::PAY_W-1:0]    req_in_payload,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [fqkd_pkg::STAT_W-1:0]   rsp_status,
   input  logic [fqkd_pkg::KEY_W-1:0]    rsp_out_key,
   input  logic [fqkd_pkg::PAY_W-1:0]    rsp_out_payload,
   input  logic [fqkd_pkg::OCC_W-1:0]    rsp_occupancy,
   input  logic                          end_of_run,
   output int                            failures,
   output int                            outstanding,
   output int                            full_seen,
   output int                            empty_seen,
   output int                            missing_seen,
   output int                            peak_occupancy
);
   import fqkd_pkg::*;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [KEY_W-1:0]  key;
      logic [PAY_W-1:0]  payload;
      logic [OCC_W-1:0]  occupancy;
   } queue_result_type;

   // Shadow copy of the queue contents, slot 0 is the head.
   logic [KEY_W-1:0] held_key     [DEPTH];
   logic [PAY_W-1:0] held_payload [DEPTH];
   int               held_count = 0;

   queue_result_type expected_results[$];

   int fail_total    = 0;
   int full_total    = 0;
   int empty_total   = 0;
   int missing_total = 0;
   int peak_total    = 0;

   // Take the entry at pos out and close the gap behind it.
   task automatic drop_slot(input int pos);
      for (int i = pos; i + 1 < held_count; i++) begin
         held_key[i]     = held_key[i + 1];
         held_payload[i] = held_payload[i + 1];
      end
      held_count--;
   endtask

   // Apply one command to the shadow queue and work out its result beat.
   task automatic run_queue_command(input logic [KIND_W-1:0] kind,
                                    input logic [KEY_W-1:0] key,
                                    input logic [PAY_W-1:0] payload,
                                    output queue_result_type result);
      int hit;
      result = '0;
      result.status = STAT_DONE;
      hit = -1;
      case (kind)
         KIND_ENQUEUE: begin
            if (held_count >= DEPTH) begin
               result.status = STAT_FULL;
            end else begin
               held_key[held_count]     = key;
               held_payload[held_count] = payload;
               held_count++;
            end
         end
         KIND_DEQUEUE: begin
            if (held_count == 0) begin
               result.status = STAT_EMPTY;
            end else begin
               result.key     = held_key[0];
               result.payload = held_payload[0];
               drop_slot(0);
            end
         end
         KIND_DELETE: begin
            for (int i = 0; i < held_count; i++) begin
               if (hit < 0 && held_key[i] == key) hit = i;
            end
            if (hit < 0) begin
               result.status = STAT_NOT_FOUND;
            end else begin
               drop_slot(hit);
            end
         end
         default: ;  // the unused code leaves the queue alone
      endcase
      result.occupancy = OCC_W'(held_count);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_total++;
      end
   endtask

   // Compare result beats first, then predict the command beat of this edge,
   // whose result can only come at a later edge.
   always @(posedge clock) begin
      queue_result_type want;
      if (reset) begin
         held_count = 0;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("result beat with no command outstanding: status %0d", rsp_status);
               fail_total++;
            end else begin
               want = expected_results.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_status));
               check_field("out_key", 64'(want.key), 64'(rsp_out_key));
               check_field("out_payload", 64'(want.payload), 64'(rsp_out_payload));
               check_field("occupancy", 64'(want.occupancy), 64'(rsp_occupancy));
            end
         end
         if (req_valid && !req_stall) begin
            run_queue_command(req_kind, req_in_key, req_in_payload, want);
            expected_results.push_back(want);
            if (want.status == STAT_FULL) full_total++;
            if (want.status == STAT_EMPTY) empty_total++;
            if (want.status == STAT_NOT_FOUND) missing_total++;
            if (held_count > peak_total) peak_total = held_count;
         end
         // Anything still expected at the end never arrived.
         if (end_of_run && expected_results.size() != 0) begin
            $error("%0d result beats never arrived", expected_results.size());
            fail_total += expected_results.size();
            expected_results.delete();
         end
      end
      failures       <= fail_total;
      outstanding    <= expected_results.size();
      full_seen      <= full_total;
      empty_seen     <= empty_total;
      missing_seen   <= missing_total;
      peak_occupancy <= peak_total;
   end

endmodule

### tb/sv/fifo_queue_with_key_delete_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_key_delete_test: testbench for the keyed queue
// Drives a directed set of commands (empty, full, duplicate and absent keys,
// head, middle and tail deletes, the unused command code) and then long runs
// of random commands that fill and drain the queue, with random idling on
// both sides, one long receiver hold-off and one pause for a full drain.
// ----------------------------------------------------------------------------
module fifo_queue_with_key_delete_test;
   import fqkd_pkg::*;

   localparam logic [KEY_W-1:0]  KEY_MAX        = 40'd999999999999;
   localparam logic [KEY_W-1:0]  KEY_DUP        = 40'h12_3456_789A;
   localparam logic [KEY_W-1:0]  KEY_ABSENT     = 40'h55_AAAA_0001;
   localparam logic [KEY_W-1:0]  KEY_BASE       = 40'h00_0000_1000;
   localparam logic [KIND_W-1:0] KIND_UNUSED    = 2'd3;
   localparam int                IDLE_PERCENT   = 32;
   localparam int                HOLD_CYCLES    = 300;
   localparam int                WATCHDOG_LIMIT = 3000;
   localparam int                RANDOM_ITEMS   = 1400;
   localparam int                SEGMENT_ITEMS  = 50;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_stall;
   logic [KIND_W-1:0]   req_kind       = KIND_ENQUEUE;
   logic [KEY_W-1:0]    req_in_key     = '0;
   logic [PAY_W-1:0]    req_in_payload = '0;
   logic                rsp_valid;
   logic                rsp_stall      = 1'b0;
   logic [STAT_W-1:0]   rsp_status;
   logic [KEY_W-1:0]    rsp_out_key;
   logic [PAY_W-1:0]    rsp_out_payload;
   logic [OCC_W-1:0]    rsp_occupancy;

   // Controls from the stimulus to the receiver.
   logic calm        = 1'b0;
   logic hold_wanted = 1'b0;
   logic end_of_run  = 1'b0;

   int failures, outstanding, full_seen, empty_seen, missing_seen, peak_occupancy;
   int sent_by_kind [4] = '{0, 0, 0, 0};
   int quiet_cycles = 0;
   logic [KEY_W-1:0] key_pool [6];

   fifo_queue_with_key_delete u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_in_key      (req_in_key),
      .req_in_payload  (req_in_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_out_key     (rsp_out_key),
      .rsp_out_payload (rsp_out_payload),
      .rsp_occupancy   (rsp_occupancy)
   );

   fqkd_queue_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_in_key      (req_in_key),
      .req_in_payload  (req_in_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_out_key     (rsp_out_key),
      .rsp_out_payload (rsp_out_payload),
      .rsp_occupancy   (rsp_occupancy),
      .end_of_run      (end_of_run),
      .failures        (failures),
      .outstanding     (outstanding),
      .full_seen       (full_seen),
      .empty_seen      (empty_seen),
      .missing_seen    (missing_seen),
      .peak_occupancy  (peak_occupancy)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random stalls, one long hold-off on request, none while calm.
   int   hold_left  = 0;
   logic hold_taken = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_wanted && !hold_taken) begin
         rsp_stall  <= 1'b1;
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   // Watchdog: too long without any beat on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [KEY_W-1:0] random_key();
      logic [63:0] wide;
      wide = {$urandom, $urandom};
      return KEY_W'(wide % 64'd1000000000000);
   endfunction

   // Mostly keys from a small pool, so that deletes hit and keys repeat.
   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(0, 99) < 65) return key_pool[$urandom_range(0, 5)];
      return random_key();
   endfunction

   function automatic logic [PAY_W-1:0] pick_payload();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) return '0;
      if (roll < 10) return '1;
      return $urandom;
   endfunction

   // Offer one command beat, after a random idle gap, and wait until taken.
   task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                            input logic [PAY_W-1:0] payload);
      while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_in_key     <= key;
      req_in_payload <= payload;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_by_kind[kind]++;
   endtask

   initial begin
      int mode;
      int roll;
      int enq_pct;
      int deq_pct;
      logic [KIND_W-1:0] kind;
      logic [KEY_W-1:0]  key;

      key_pool[0] = '0;
      key_pool[1] = KEY_MAX;
      key_pool[2] = KEY_DUP;
      for (int i = 3; i < 6; i++) key_pool[i] = random_key();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part: commands on an empty queue, then the unused code.
      send_beat(KIND_DEQUEUE, '0, '0);
      send_beat(KIND_DELETE, KEY_DUP, '0);
      send_beat(KIND_UNUSED, KEY_MAX, '1);
      // Fill the queue with extreme keys and a key held twice.
      for (int i = 0; i < DEPTH; i++) begin
         if (i == 0) key = '0;
         else if (i == 1) key = KEY_MAX;
         else if (i == 3 || i == 7) key = KEY_DUP;
         else key = KEY_BASE + KEY_W'(i);
         send_beat(KIND_ENQUEUE, key, (i == 0) ? '0 : (i == 1) ? '1 : PAY_W'($urandom));
      end
      // Enqueue when full, the repeated key, an absent key, tail and head.
      send_beat(KIND_ENQUEUE, KEY_ABSENT, '1);
      send_beat(KIND_DELETE, KEY_DUP, '0);
      send_beat(KIND_DELETE, KEY_ABSENT, '0);
      send_beat(KIND_DELETE, KEY_BASE + KEY_W'(DEPTH - 1), '0);
      send_beat(KIND_DELETE, '0, '0);
      send_beat(KIND_DEQUEUE, '0, '0);

      // Random part in segments that lean towards filling or draining.
      mode = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % SEGMENT_ITEMS == 0) mode = $urandom_range(0, 2);
         if (n == 300) hold_wanted <= 1'b1;
         if (n == 700) calm <= 1'b1;
         if (n == 950) calm <= 1'b0;
         if (n == 1100) begin
            // Sender pause until the queue has answered everything.
            req_valid <= 1'b0;
            @(posedge clock);
            while (outstanding != 0) @(posedge clock);
         end
         case (mode)
            0:       begin enq_pct = 70; deq_pct = 15; end
            1:       begin enq_pct = 20; deq_pct = 50; end
            default: begin enq_pct = 40; deq_pct = 30; end
         endcase
         roll = $urandom_range(0, 99);
         if (roll == 99) kind = KIND_UNUSED;
         else if (roll < enq_pct) kind = KIND_ENQUEUE;
         else if (roll < enq_pct + deq_pct) kind = KIND_DEQUEUE;
         else kind = KIND_DELETE;
         send_beat(kind, pick_key(), pick_payload());
      end
      req_valid <= 1'b0;

      // Drain, allow for the registered result, then look for leftovers.
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      end_of_run <= 1'b1;
      repeat (2) @(posedge clock);

      $display("Sent %0d enqueue, %0d dequeue, %0d delete and %0d unused-code beats.",
               sent_by_kind[KIND_ENQUEUE], sent_by_kind[KIND_DEQUEUE],
               sent_by_kind[KIND_DELETE], sent_by_kind[KIND_UNUSED]);
      $display("Peak occupancy %0d; %0d full, %0d empty, %0d key-not-found results.",
               peak_occupancy, full_seen, empty_seen, missing_seen);
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### fifo_queue_with_key_delete.f
sv/fqkd_pkg.sv
sv/fqkd_cell.sv
sv/fifo_queue_with_key_delete.sv
tb/sv/fqkd_queue_checker.sv
tb/sv/fifo_queue_with_key_delete_test.sv
